// File: rtl/fbce_pkg.sv
// Package: key-derived keystream terms, digit-add step and keystream evaluation.
package fbce_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_HEAD = 2'd0;
    localparam logic [1:0] CFG_KEY_MID  = 2'd1;
    localparam logic [1:0] CFG_KEY_TAIL = 2'd2;

    localparam logic [39:0] ESC_PATTERN  = 40'h0145FCC7A2;
    localparam logic [7:0]  ESC_LAST     = 8'hA2;
    localparam logic [7:0]  PREV_INIT    = 8'hFF;
    localparam logic [7:0]  DIGIT_MAX    = 8'h0F;
    localparam logic [2:0]  HIST_FULL    = 3'd5;
    localparam logic [2:0]  SETTLE_LEN   = 3'd5;
    localparam int          KEY_BYTES    = 19;

    // Key-only terms of the keystream, one set per key.
    // Path A: first sum carried out (sa shifted right with a leading 1).
    // Path B: no carry (sa rotated); B terms indexed by the carry out of digit 10.
    typedef struct packed {
        logic [7:0]      m10;
        logic            c1;
        logic [7:0]      s3;
        logic [7:0]      s4;
        logic [7:0]      s8;
        logic [7:0]      s9;
        logic [7:0]      sb0;
        logic [7:0]      sb1;
        logic [7:0]      sb10;
        logic            e2a;
        logic [7:0]      t3a;
        logic [7:0]      t4a;
        logic [7:0]      t8a;
        logic [7:0]      t9a;
        logic [1:0]      e1b;
        logic [1:0][7:0] t3b;
        logic [1:0][7:0] t4b;
        logic [1:0][7:0] t8b;
        logic [1:0][7:0] t9b;
    } ks_pre_t;

    // One byte digit: wrapped sum, carry when the sum exceeds 0x0F. Returns {carry, sum}.
    function automatic logic [8:0] dstep(input logic [7:0] a, input logic [7:0] b,
                                         input logic cin);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        return {(s[7:0] > DIGIT_MAX), s[7:0]};
    endfunction

    function automatic logic [7:0] confuse(input logic [7:0] v0, input logic [7:0] v1,
                                           input logic [7:0] v2, input logic [7:0] v3);
        return 8'hFF ^ v3 ^ v2 ^ (v3 & v1) ^ (v2 & v1) ^ (v3 & v2 & v0)
               ^ (v3 & v1 & v0) ^ (v2 & v1 & v0) ^ (v3 & v2 & v1 & v0);
    endfunction

    // Keystream byte for a given previous plaintext byte: three short digit adds.
    function automatic logic [7:0] keystream(input ks_pre_t pre, input logic [7:0] prev);
        logic [8:0] r0;
        logic [8:0] r1;
        logic [8:0] r2;
        logic       e10;
        logic       ce;
        logic [7:0] v0;
        logic [7:0] v1;
        logic [7:0] v2;
        logic [7:0] v3;
        r0  = dstep(prev, pre.m10, pre.c1);
        e10 = 1'b0;
        if (r0[8])
        begin
            r1 = dstep(r0[7:0], pre.sb1, pre.e2a);
            r2 = dstep(8'h01, pre.sb0, r1[8]);
            ce = r2[8];
            v0 = pre.s3;
            v1 = pre.s8;
            v2 = ce ? pre.t3a : pre.t4a;
            v3 = ce ? pre.t8a : pre.t9a;
        end
        else
        begin
            r1  = dstep(r0[7:0], pre.sb10, 1'b0);
            e10 = r1[8];
            r2  = dstep(r0[7:0], pre.sb0, pre.e1b[e10]);
            ce  = r2[8];
            v0  = pre.s4;
            v1  = pre.s9;
            v2  = ce ? pre.t3b[e10] : pre.t4b[e10];
            v3  = ce ? pre.t8b[e10] : pre.t9b[e10];
        end
        return confuse(v0, v1, v2, v3);
    endfunction

endpackage

// File: rtl/feedback_byte_cipher_with_escape_unit.sv
// Top level: feedback byte cipher with escape stuffing, key precompute and result queue.
//
// Usage
//   s_axis: one beat per byte. tdata = in_byte; tuser[0] = op (0 encrypt, 1 decrypt),
//   tuser[1] = start_of_message (restart the feedback at 0xFF and clear the escape history).
//   m_axis: result beats. tdata = out_byte; tlast marks the final result of one input beat.
//   cfg: one beat writes a key register (index 0 key_head, 1 key_mid, 2 key_tail);
//   other indexes are ignored. cfg_ready is always high.
// Timing
//   The keystream is evaluated in the accepting cycle from the state registers and a set of
//   key-only terms, so a result is in the queue the cycle after its input beat.
//   Throughput: one input beat per cycle while s_axis_tready is high. An escaped run (encrypt of
//   01 45 FC C7 A2) yields two result beats, so output drain of the 4-entry queue sets the
//   sustained rate for all-escape traffic.
//   The key-only terms come from a five-stage pipeline of digit-add chains; s_axis_tready
//   stays low after reset and after every key write while it settles.
// Reset and stall
//   Reset clears the key to zero, the feedback byte to 0xFF and the history, and empties
//   the queue. When m_axis stalls, the queue fills; s_axis_tready drops once fewer than
//   two entries are free, and nothing is lost or repeated.
module feedback_byte_cipher_with_escape_unit
    import fbce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,   // [0] op, [1] start_of_message
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last_of_run
);

    // ---------------- key registers ----------------
    logic [63:0] key_head_reg;
    logic [63:0] key_mid_reg;
    logic [23:0] key_tail_reg;
    logic [2:0]  settle_reg;
    logic        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_head_reg <= '0;
            key_mid_reg  <= '0;
            key_tail_reg <= '0;
            settle_reg   <= SETTLE_LEN;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_KEY_HEAD: key_head_reg <= cfg_data;
                    CFG_KEY_MID:  key_mid_reg  <= cfg_data;
                    CFG_KEY_TAIL: key_tail_reg <= cfg_data[23:0];
                    default:      ;
                endcase
            end
            if (cfg_fire)
                settle_reg <= SETTLE_LEN;
            else if (settle_reg != 3'd0)
                settle_reg <= settle_reg - 3'd1;
        end
    end

    // key_b[j] is message byte j+1 (message byte 0 is the feedback byte)
    logic [7:0] key_b [KEY_BYTES];

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            key_b[j]     = key_head_reg[63 - 8*j -: 8];
            key_b[8 + j] = key_mid_reg[63 - 8*j -: 8];
        end
        for (int j = 0; j < 3; j++)
            key_b[16 + j] = key_tail_reg[23 - 8*j -: 8];
    end

    // ---------------- key precompute pipeline ----------------
    // stage 1: low halves of a+b and b+b chains (digits 9..5)
    logic [7:0] st1_s_reg [5:9];
    logic [7:0] st1_u_reg [5:9];
    logic       st1_cs_reg;
    logic       st1_cu_reg;
    logic [7:0] st1_s_next [5:9];
    logic [7:0] st1_u_next [5:9];
    logic       st1_cs_next;
    logic       st1_cu_next;

    always_comb
    begin
        logic [8:0] r;
        logic       cs;
        logic       cu;
        cs = 1'b0;
        cu = 1'b0;
        for (int i = 9; i >= 5; i--)
        begin
            r = dstep(key_b[i - 1], key_b[9 + i], cs);
            st1_s_next[i] = r[7:0];
            cs = r[8];
            r = dstep(key_b[9 + i], key_b[9 + i], cu);
            st1_u_next[i] = r[7:0];
            cu = r[8];
        end
        st1_cs_next = cs;
        st1_cu_next = cu;
    end

    // stage 2: finish both chains; sa digits 1..9 (key part), full b+b sum
    logic [7:0] sa_reg [1:9];
    logic [7:0] sb_reg [0:10];
    logic       c1_reg;
    logic [7:0] sa_next [1:9];
    logic [7:0] sb_next [0:10];
    logic       c1_next;

    always_comb
    begin
        logic [8:0] r;
        logic [7:0] u [0:9];
        logic       cs;
        logic       cu;
        cs = st1_cs_reg;
        cu = st1_cu_reg;
        for (int i = 9; i >= 5; i--)
        begin
            sa_next[i] = st1_s_reg[i];
            u[i]       = st1_u_reg[i];
        end
        for (int i = 4; i >= 1; i--)
        begin
            r = dstep(key_b[i - 1], key_b[9 + i], cs);
            sa_next[i] = r[7:0];
            cs = r[8];
        end
        for (int i = 4; i >= 0; i--)
        begin
            r = dstep(key_b[9 + i], key_b[9 + i], cu);
            u[i] = r[7:0];
            cu = r[8];
        end
        c1_next = cs;
        // carry out: leading 1 then digits; else digits then digit 0 repeated
        if (cu)
        begin
            sb_next[0] = 8'h01;
            for (int k = 1; k <= 10; k++)
                sb_next[k] = u[k - 1];
        end
        else
        begin
            for (int k = 0; k <= 9; k++)
                sb_next[k] = u[k];
            sb_next[10] = u[0];
        end
    end

    // stage 3: upper digits of the second-level sum, both paths
    logic [7:0]      t8a_reg;
    logic [7:0]      t9a_reg;
    logic            e6a_reg;
    logic [1:0][7:0] t8b_reg;
    logic [1:0][7:0] t9b_reg;
    logic [1:0]      e5b_reg;
    logic [7:0]      t8a_next;
    logic [7:0]      t9a_next;
    logic            e6a_next;
    logic [1:0][7:0] t8b_next;
    logic [1:0][7:0] t9b_next;
    logic [1:0]      e5b_next;

    always_comb
    begin
        logic [8:0] r;
        logic       e;
        t8a_next = '0;
        t9a_next = '0;
        t8b_next = '0;
        t9b_next = '0;
        // path A: sa[k] = s(k-1), digits 10..6
        e = 1'b0;
        for (int k = 10; k >= 6; k--)
        begin
            r = dstep(sa_reg[k - 1], sb_reg[k], e);
            if (k == 9)
                t9a_next = r[7:0];
            if (k == 8)
                t8a_next = r[7:0];
            e = r[8];
        end
        e6a_next = e;
        // path B: sa[k] = s(k), digits 9..5, per carry from digit 10
        for (int j = 0; j < 2; j++)
        begin
            e = j[0];
            for (int k = 9; k >= 5; k--)
            begin
                r = dstep(sa_reg[k], sb_reg[k], e);
                if (k == 9)
                    t9b_next[j] = r[7:0];
                if (k == 8)
                    t8b_next[j] = r[7:0];
                e = r[8];
            end
            e5b_next[j] = e;
        end
    end

    // stage 4: lower digits; assemble key-only term set
    ks_pre_t pre_reg;
    ks_pre_t pre_next;

    always_comb
    begin
        logic [8:0] r;
        logic       e;
        pre_next      = '0;
        pre_next.m10  = key_b[9];
        pre_next.c1   = c1_reg;
        pre_next.s3   = sa_reg[3];
        pre_next.s4   = sa_reg[4];
        pre_next.s8   = sa_reg[8];
        pre_next.s9   = sa_reg[9];
        pre_next.sb0  = sb_reg[0];
        pre_next.sb1  = sb_reg[1];
        pre_next.sb10 = sb_reg[10];
        pre_next.t8a  = t8a_reg;
        pre_next.t9a  = t9a_reg;
        pre_next.t8b  = t8b_reg;
        pre_next.t9b  = t9b_reg;
        e = e6a_reg;
        for (int k = 5; k >= 2; k--)
        begin
            r = dstep(sa_reg[k - 1], sb_reg[k], e);
            if (k == 4)
                pre_next.t4a = r[7:0];
            if (k == 3)
                pre_next.t3a = r[7:0];
            e = r[8];
        end
        pre_next.e2a = e;
        for (int j = 0; j < 2; j++)
        begin
            e = e5b_reg[j];
            for (int k = 4; k >= 1; k--)
            begin
                r = dstep(sa_reg[k], sb_reg[k], e);
                if (k == 4)
                    pre_next.t4b[j] = r[7:0];
                if (k == 3)
                    pre_next.t3b[j] = r[7:0];
                e = r[8];
            end
            pre_next.e1b[j] = e;
        end
    end

    // stage 5: keystream after the escape's last byte, used for the stuffed zero
    logic [7:0] ks_esc_reg;

    always_ff @(posedge clk)
    begin
        st1_s_reg  <= st1_s_next;
        st1_u_reg  <= st1_u_next;
        st1_cs_reg <= st1_cs_next;
        st1_cu_reg <= st1_cu_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        c1_reg     <= c1_next;
        t8a_reg    <= t8a_next;
        t9a_reg    <= t9a_next;
        e6a_reg    <= e6a_next;
        t8b_reg    <= t8b_next;
        t9b_reg    <= t9b_next;
        e5b_reg    <= e5b_next;
        pre_reg    <= pre_next;
        ks_esc_reg <= keystream(pre_reg, ESC_LAST);
    end

    // ---------------- per-byte datapath ----------------
    logic [7:0]  prev_reg;
    logic [39:0] hist_reg;
    logic [2:0]  hcnt_reg;
    logic        zdrop_reg;
    logic [7:0]  prev_next;
    logic [39:0] hist_next;
    logic [2:0]  hcnt_next;
    logic        zdrop_next;

    logic        in_fire;
    logic        in_op;
    logic        in_som;
    logic [7:0]  ks;
    logic [1:0]  push_cnt;
    logic [8:0]  push0;
    logic [8:0]  push1;

    assign in_op  = s_axis_tuser[0];
    assign in_som = s_axis_tuser[1];

    always_comb
    begin
        logic [7:0]  prev_e;
        logic [39:0] hist_e;
        logic [2:0]  hcnt_e;
        logic        zdrop_e;
        logic [7:0]  val;
        logic [39:0] hist_p;
        logic [2:0]  hcnt_p;
        // start of message restarts the feedback first
        prev_e  = in_som ? PREV_INIT : prev_reg;
        hist_e  = in_som ? '0 : hist_reg;
        hcnt_e  = in_som ? 3'd0 : hcnt_reg;
        zdrop_e = in_som ? 1'b0 : zdrop_reg;

        ks     = keystream(pre_reg, prev_e);
        val    = s_axis_tdata ^ ks;
        hcnt_p = (hcnt_e < HIST_FULL) ? hcnt_e + 3'd1 : hcnt_e;
        hist_p = {hist_e[31:0], s_axis_tdata};

        prev_next  = prev_reg;
        hist_next  = hist_reg;
        hcnt_next  = hcnt_reg;
        zdrop_next = zdrop_reg;
        push_cnt   = 2'd0;
        push0      = {1'b1, val};
        push1      = {1'b1, ks_esc_reg};

        if (in_fire)
        begin
            zdrop_next = 1'b0;
            if (!in_op)
            begin
                // encrypt: history holds plaintext
                hist_next = hist_p;
                hcnt_next = hcnt_p;
                if (hcnt_p == HIST_FULL && hist_p == ESC_PATTERN)
                begin
                    // stuffed zero follows, encrypted under feedback 0xA2
                    push0     = {1'b0, val};
                    push_cnt  = 2'd2;
                    prev_next = 8'h00;
                end
                else
                begin
                    push_cnt  = 2'd1;
                    prev_next = s_axis_tdata;
                end
            end
            else
            begin
                prev_next = val;
                if (hcnt_e == HIST_FULL && hist_e == ESC_PATTERN && val == 8'h00 && !zdrop_e)
                begin
                    // stuffed zero: swallow it, history unchanged
                    zdrop_next = 1'b1;
                    hist_next  = hist_e;
                    hcnt_next  = hcnt_e;
                end
                else
                begin
                    hist_next = {hist_e[31:0], val};
                    hcnt_next = hcnt_p;
                    push_cnt  = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= PREV_INIT;
            hist_reg  <= '0;
            hcnt_reg  <= 3'd0;
            zdrop_reg <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            hist_reg  <= hist_next;
            hcnt_reg  <= hcnt_next;
            zdrop_reg <= zdrop_next;
        end
    end

    // ---------------- result queue (4 entries of {last, byte}) ----------------
    logic [8:0] q_mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       out_fire;

    assign s_axis_tready = (settle_reg == 3'd0) && (cnt_reg <= 3'd2);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = q_mem[rd_ptr_reg][7:0];
    assign m_axis_tlast  = q_mem[rd_ptr_reg][8];
    assign out_fire      = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            q_mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, push_cnt} - {2'd0, out_fire};
        end
    end

    // ---------------- assertions ----------------
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue overflow");

    a_hcnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= HIST_FULL)
        else $error("history count past saturation");

    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !s_axis_tready)
        else $error("input taken while key terms settle");

    a_drop_prev: assert property (@(posedge clk) disable iff (!rst_n)
        zdrop_reg |-> (prev_reg == 8'h00))
        else $error("dropped zero left nonzero feedback");

    a_esc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2 && !out_fire) |=> (cnt_reg == $past(cnt_reg) + 3'd2))
        else $error("escape pair not queued");

endmodule
